// File: src/i64alu_pkg.sv
// Opcodes and stream field layout shared by the 64-bit integer ALU.
`default_nettype none
package i64alu_pkg;

    localparam int CMD_W   = 4;
    localparam int FIELD_W = 64;
    localparam int SHAMT_W = 7;
    localparam int CMP_W   = 2;

    localparam int S_CMD_LSB   = 0;
    localparam int S_A_LSB     = S_CMD_LSB + CMD_W;
    localparam int S_B_LSB     = S_A_LSB + FIELD_W;
    localparam int S_SH_LSB    = S_B_LSB + FIELD_W;
    localparam int S_USED_W    = S_SH_LSB + SHAMT_W;
    localparam int S_TDATA_W   = ((S_USED_W + 7) / 8) * 8;

    localparam int M_RES_LSB   = 0;
    localparam int M_REM_LSB   = M_RES_LSB + FIELD_W;
    localparam int M_CMP_LSB   = M_REM_LSB + FIELD_W;
    localparam int M_DZ_LSB    = M_CMP_LSB + CMP_W;
    localparam int M_USED_W    = M_DZ_LSB + 1;
    localparam int M_TDATA_W   = ((M_USED_W + 7) / 8) * 8;

    localparam logic [CMD_W-1:0] OP_ADD = 4'd0;
    localparam logic [CMD_W-1:0] OP_SUB = 4'd1;
    localparam logic [CMD_W-1:0] OP_MUL = 4'd2;
    localparam logic [CMD_W-1:0] OP_DIV = 4'd3;
    localparam logic [CMD_W-1:0] OP_MOD = 4'd4;
    localparam logic [CMD_W-1:0] OP_AND = 4'd5;
    localparam logic [CMD_W-1:0] OP_OR  = 4'd6;
    localparam logic [CMD_W-1:0] OP_XOR = 4'd7;
    localparam logic [CMD_W-1:0] OP_NOT = 4'd8;
    localparam logic [CMD_W-1:0] OP_NEG = 4'd9;
    localparam logic [CMD_W-1:0] OP_SHL = 4'd10;
    localparam logic [CMD_W-1:0] OP_SHR = 4'd11;
    localparam logic [CMD_W-1:0] OP_CMP = 4'd12;

    localparam logic [CMP_W-1:0] CMP_LT = 2'b11;
    localparam logic [CMP_W-1:0] CMP_EQ = 2'b00;
    localparam logic [CMP_W-1:0] CMP_GT = 2'b01;

endpackage
`default_nettype wire

// File: src/int64_signed_alu_core.sv
// Pipelined signed integer ALU with multiply and restoring divide.
`default_nettype none
// Takes one word per cycle and returns one result word per input word, in order.
// The accepting edge loads the first stage: the simple operations and the partial
// products of the split multiplier. One more stage sums the products. DATA_WIDTH
// stages of the restoring divider follow, one quotient bit each. Last comes the
// output register, where signs are restored. Every operation walks the same
// pipeline, so results leave in order. The whole pipeline holds while a result
// waits on m_tready. Operands use their low DATA_WIDTH bits as a signed value;
// results are sign-extended to 64 bits.
module int64_signed_alu_core #(
    parameter int DATA_WIDTH = 64
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // command[3:0], operand_a[67:4], operand_b[131:68], shift_amount[138:132]
    input  wire logic [i64alu_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // result_value[63:0], remainder_value[127:64], compare_result[129:128],
    // divide_by_zero[130]
    output logic [i64alu_pkg::M_TDATA_W-1:0]         m_tdata
);
    import i64alu_pkg::*;

    localparam int W    = DATA_WIDTH;
    localparam int H    = (W + 1) / 2;
    localparam int HH   = W - H;
    localparam int LAST = W + 2;

    typedef struct packed {
        logic             valid;
        logic [CMD_W-1:0] cmd;
        logic             is_div;
        logic             dz;
        logic             an;
        logic             bn;
        logic [CMP_W-1:0] cmp;
        logic [W-1:0]     res;
        logic [W-1:0]     mb;
        logic [W-1:0]     r;
        logic [W-1:0]     q;
        logic [W-1:0]     pl;
        logic [HH-1:0]    pc1;
        logic [HH-1:0]    pc2;
    } stage_t;

    stage_t pipe_reg [1:LAST];
    stage_t pipe_next [1:LAST];

    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                 m_tvalid_reg;
    logic                 en;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Stage 1: decode, simple ops, magnitudes and partial products.
    logic [CMD_W-1:0]   in_cmd;
    logic [W-1:0]       in_a, in_b;
    logic [SHAMT_W-1:0] in_sh;

    assign in_cmd = s_tdata[S_CMD_LSB +: CMD_W];
    assign in_a   = s_tdata[S_A_LSB +: W];
    assign in_b   = s_tdata[S_B_LSB +: W];
    assign in_sh  = s_tdata[S_SH_LSB +: SHAMT_W];

    always_comb begin
        logic lt, gt;
        logic [W-1:0] r1;
        lt = $signed(in_a) < $signed(in_b);
        gt = $signed(in_a) > $signed(in_b);
        pipe_next[1]        = '0;
        pipe_next[1].valid  = s_tvalid;
        pipe_next[1].cmd    = in_cmd;
        pipe_next[1].cmp    = lt ? CMP_LT : (gt ? CMP_GT : CMP_EQ);
        pipe_next[1].is_div = (in_cmd == OP_DIV) || (in_cmd == OP_MOD);
        pipe_next[1].dz     = pipe_next[1].is_div && (in_b == '0);
        pipe_next[1].an     = in_a[W-1];
        pipe_next[1].bn     = in_b[W-1];
        pipe_next[1].q      = in_a[W-1] ? (~in_a + W'(1)) : in_a;
        pipe_next[1].mb     = in_b[W-1] ? (~in_b + W'(1)) : in_b;
        pipe_next[1].pl     = W'(in_a[H-1:0] * in_b[H-1:0]);
        pipe_next[1].pc1    = HH'(in_a[H-1:0] * in_b[W-1:H]);
        pipe_next[1].pc2    = HH'(in_a[W-1:H] * in_b[H-1:0]);
        case (in_cmd)
            OP_ADD:  r1 = in_a + in_b;
            OP_SUB:  r1 = in_a - in_b;
            OP_AND:  r1 = in_a & in_b;
            OP_OR:   r1 = in_a | in_b;
            OP_XOR:  r1 = in_a ^ in_b;
            OP_NOT:  r1 = ~in_a;
            OP_NEG:  r1 = ~in_a + W'(1);
            OP_SHL:  r1 = (in_sh >= SHAMT_W'(W)) ? '0 : (in_a << in_sh);
            OP_SHR:  r1 = (in_sh >= SHAMT_W'(W)) ? '0 : (in_a >> in_sh);
            OP_CMP:  r1 = lt ? '1 : (gt ? W'(1) : '0);
            default: r1 = '0;
        endcase
        pipe_next[1].res = r1;
    end

    // Stage 2: sum the multiplier partial products.
    always_comb begin
        logic [W-1:0] prod;
        prod = pipe_reg[1].pl + {pipe_reg[1].pc1 + pipe_reg[1].pc2, {H{1'b0}}};
        pipe_next[2] = pipe_reg[1];
        if (pipe_reg[1].cmd == OP_MUL) begin
            pipe_next[2].res = prod;
        end
    end

    // Divider: one restoring step per stage, dividend shifts out of q.
    for (genvar k = 3; k <= LAST; k++) begin : g_div
        always_comb begin
            logic [W:0] rs, d;
            rs = {pipe_reg[k-1].r, pipe_reg[k-1].q[W-1]};
            d  = rs - {1'b0, pipe_reg[k-1].mb};
            pipe_next[k] = pipe_reg[k-1];
            if (!d[W]) begin
                pipe_next[k].r = d[W-1:0];
            end else begin
                pipe_next[k].r = rs[W-1:0];
            end
            pipe_next[k].q = {pipe_reg[k-1].q[W-2:0], ~d[W]};
        end
    end

    for (genvar k = 1; k <= LAST; k++) begin : g_stage
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                pipe_reg[k].valid <= 1'b0;
            end else if (en) begin
                pipe_reg[k] <= pipe_next[k];
            end
        end
    end

    // Output: restore signs and select the result.
    always_comb begin
        logic [W-1:0] qv, rv, res, rem;
        stage_t t;
        t   = pipe_reg[LAST];
        qv  = (t.an ^ t.bn) ? (~t.q + W'(1)) : t.q;
        rv  = t.an ? (~t.r + W'(1)) : t.r;
        res = t.res;
        rem = '0;
        if (t.is_div) begin
            if (t.dz) begin
                res = '0;
            end else begin
                res = (t.cmd == OP_DIV) ? qv : rv;
                rem = rv;
            end
        end
        m_tdata_next = '0;
        m_tdata_next[M_RES_LSB +: FIELD_W] = FIELD_W'($signed(res));
        m_tdata_next[M_REM_LSB +: FIELD_W] = FIELD_W'($signed(rem));
        m_tdata_next[M_CMP_LSB +: CMP_W]   = t.cmp;
        m_tdata_next[M_DZ_LSB]             = t.dz;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= pipe_reg[LAST].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    a_dz_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[M_DZ_LSB] |->
            (m_tdata[M_RES_LSB +: FIELD_W] == '0) && (m_tdata[M_REM_LSB +: FIELD_W] == '0))
        else $error("divide by zero result not cleared");

    a_cmp_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[M_CMP_LSB +: CMP_W] != 2'b10))
        else $error("illegal compare code");

    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pipe_reg[LAST].valid && pipe_reg[LAST].is_div && !pipe_reg[LAST].dz |->
            (pipe_reg[LAST].r < pipe_reg[LAST].mb))
        else $error("divider remainder not below divisor");

    a_dz_only_div: assert property (@(posedge aclk) disable iff (!aresetn)
        pipe_reg[1].valid && pipe_reg[1].dz |-> pipe_reg[1].is_div)
        else $error("divide by zero flagged on non-divide");

endmodule
`default_nettype wire

// File: dv/int64_signed_alu_core_tb.sv
// Self-checking stream testbench for the 64-bit signed integer ALU core.
`default_nettype none
module int64_signed_alu_core_tb;
    import i64alu_pkg::*;

    localparam int LATENCY = 64 + 3;

    typedef struct packed {
        logic [SHAMT_W-1:0] shamt;
        logic [63:0]        b;
        logic [63:0]        a;
        logic [CMD_W-1:0]   cmd;
    } alu_op_t;

    typedef struct packed {
        logic               dz;
        logic [CMP_W-1:0]   cmp;
        logic [63:0]        rem;
        logic [63:0]        res;
    } alu_res_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    alu_op_t  pending_ops[$];
    alu_res_t expected_results[$];
    int mismatches = 0;
    bit stimulus_done = 1'b0;
    bit hold_for_drain = 1'b0;
    bit quiet_phase = 1'b0;

    int64_signed_alu_core #(.DATA_WIDTH(64)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic alu_res_t alu_predict(alu_op_t op);
        alu_res_t r;
        logic signed [63:0] sa, sb;
        logic [63:0] ma, mb, q, rm;
        sa = op.a;
        sb = op.b;
        r = '0;
        r.cmp = (sa < sb) ? CMP_LT : (sa > sb) ? CMP_GT : CMP_EQ;
        case (op.cmd)
            OP_ADD: r.res = op.a + op.b;
            OP_SUB: r.res = op.a - op.b;
            OP_MUL: r.res = op.a * op.b;
            OP_DIV, OP_MOD: begin
                if (op.b == 0) begin
                    r.dz = 1'b1;
                end else begin
                    ma = op.a[63] ? -op.a : op.a;
                    mb = op.b[63] ? -op.b : op.b;
                    q = ma / mb;
                    rm = ma % mb;
                    if (op.a[63] != op.b[63]) q = -q;
                    if (op.a[63]) rm = -rm;
                    r.rem = rm;
                    r.res = (op.cmd == OP_DIV) ? q : rm;
                end
            end
            OP_AND: r.res = op.a & op.b;
            OP_OR:  r.res = op.a | op.b;
            OP_XOR: r.res = op.a ^ op.b;
            OP_NOT: r.res = ~op.a;
            OP_NEG: r.res = -op.a;
            OP_SHL: r.res = (op.shamt >= 64) ? 64'd0 : op.a << op.shamt;
            OP_SHR: r.res = (op.shamt >= 64) ? 64'd0 : op.a >> op.shamt;
            OP_CMP: r.res = {{62{r.cmp[1]}}, r.cmp};
            default: r.res = '0;
        endcase
        return r;
    endfunction

    function automatic logic [63:0] rand_operand();
        case ($urandom_range(0, 7))
            0: return 64'h8000_0000_0000_0000;
            1: return 64'h7FFF_FFFF_FFFF_FFFF;
            2: return 64'(signed'($urandom_range(0, 20)) - 10);
            3: return {32'd0, $urandom()};
            4: return {{32{1'b1}}, $urandom()};
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    task automatic add_op(logic [CMD_W-1:0] cmd, logic [63:0] a, logic [63:0] b,
                          logic [SHAMT_W-1:0] sh);
        alu_op_t op;
        op.cmd = cmd;
        op.a = a;
        op.b = b;
        op.shamt = sh;
        pending_ops.push_back(op);
    endtask

    // driver
    always @(posedge aclk) begin
        alu_op_t op;
        if (aresetn) begin
            if (!s_tvalid || s_tready) begin
                if (s_tvalid)
                    expected_results.push_back(alu_predict(alu_op_t'(s_tdata[S_USED_W-1:0])));
                if (pending_ops.size() > 0 && !hold_for_drain &&
                    (quiet_phase || $urandom_range(0, 99) >= 30)) begin
                    op = pending_ops.pop_front();
                    s_tdata <= S_TDATA_W'(op);
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        alu_res_t got, want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = alu_res_t'(m_tdata[M_USED_W-1:0]);
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result word %h", got);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: res %h/%h rem %h/%h cmp %b/%b dz %b/%b",
                                     want.res, got.res, want.rem, got.rem,
                                     want.cmp, got.cmp, want.dz, got.dz);
                    end
                end
            end
            m_tready <= quiet_phase || $urandom_range(0, 99) >= 30;
        end
    end

    initial begin
        logic [63:0] edge_vals[6];
        edge_vals = '{64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 64'd0,
                      64'd1, {64{1'b1}}, 64'd7};
        // directed: every opcode, extremes, zero divisor, min / -1, long shifts
        for (int c = 0; c < 16; c++)
            add_op(CMD_W'(c), edge_vals[c % 6], edge_vals[(c + 3) % 6], 7'(c * 9));
        add_op(OP_DIV, 64'h8000_0000_0000_0000, {64{1'b1}}, 7'd0);
        add_op(OP_MOD, 64'h8000_0000_0000_0000, {64{1'b1}}, 7'd0);
        add_op(OP_DIV, -64'sd7, 64'd2, 7'd0);
        add_op(OP_MOD, -64'sd7, 64'd2, 7'd0);
        add_op(OP_MOD, 64'd5, 64'd0, 7'd0);
        add_op(OP_SHL, {64{1'b1}}, 64'd0, 7'd64);
        add_op(OP_SHR, {64{1'b1}}, 64'd0, 7'd127);
        add_op(OP_SHR, {64{1'b1}}, 64'd0, 7'd63);
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        wait (pending_ops.size() == 0);
        hold_for_drain = 1'b1;
        wait (expected_results.size() == 0 && !s_tvalid);
        hold_for_drain = 1'b0;
        for (int i = 0; i < 2000; i++) begin
            logic [CMD_W-1:0] cmd;
            cmd = ($urandom_range(0, 19) == 0) ? CMD_W'($urandom_range(13, 15))
                                              : CMD_W'($urandom_range(0, 12));
            add_op(cmd, rand_operand(),
                   ($urandom_range(0, 15) == 0) ? 64'd0 : rand_operand(),
                   ($urandom_range(0, 3) == 0) ? 7'($urandom_range(64, 127))
                                               : 7'($urandom_range(0, 63)));
            if (i == 1000) begin
                wait (pending_ops.size() < 10);
                quiet_phase = 1'b1;
            end
            if (i == 1300) begin
                wait (pending_ops.size() < 10);
                quiet_phase = 1'b0;
            end
        end
        wait (pending_ops.size() == 0 && !s_tvalid);
        wait (expected_results.size() == 0);
        repeat (LATENCY + 10) @(posedge aclk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("int64_signed_alu_core_tb passed");
        else
            $display("int64_signed_alu_core_tb failed");
        $finish;
    end

    initial begin
        #2000000;
        $display("int64_signed_alu_core_tb failed");
        $finish;
    end
endmodule
`default_nettype wire

// File: files.f
src/i64alu_pkg.sv
src/int64_signed_alu_core.sv
dv/int64_signed_alu_core_tb.sv
